[rtl/core/lmf_pkg.sv]
package lmf_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_HEIGHT    = 2'd2;

    // reset frame size
    localparam int RESET_WIDTH  = 1475;
    localparam int RESET_HEIGHT = 1679;

    // result kinds
    localparam logic KIND_SPOT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [22:0] TOTAL_MAX = 23'h7FFFFF;

    // event queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    // one event per pixel: up to four spot centres in raster order
    // (upper-left, upper-right, lower-left, lower-right) plus frame end
    typedef struct packed {
        logic [3:0]             hit;
        logic [3:0][31:0]       val;
        logic [10:0]            xa;
        logic [10:0]            xb;
        logic [10:0]            ya;
        logic [10:0]            yb;
        logic                   fin;
    } t_event;

endpackage

[rtl/core/lmf_queue.sv]
module lmf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lmf_pkg::t_event i_event,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nempty,
    output lmf_pkg::t_event o_event
);
    import lmf_pkg::*;

    t_event           r_mem [QDEPTH];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QPW:0]     r_cnt;

    assign o_full   = (r_cnt == (QPW+1)'(QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_event  = r_mem[r_rp];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QPW'(1);
            if (i_pop)  r_rp <= r_rp + QPW'(1);
            r_cnt <= r_cnt + (QPW+1)'(i_push) - (QPW+1)'(i_pop);
        end
    end

    // store word
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_event;
    end

endmodule

[rtl/core/lmf_front.sv]
module lmf_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_acc,
    input  logic [31:0]                         i_pixel_value,
    input  logic [31:0]                         i_thr,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_h,
    input  logic                                i_restart,
    output logic                                o_push,
    output lmf_pkg::t_event                     o_event
);
    import lmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          lastc;
    logic          lastr;

    logic [31:0]   rd [4];

    logic          r_v1;
    logic [31:0]   r_pix1;
    logic [CW-1:0] r_col1;
    logic [RW-1:0] r_row1;
    logic          r_lastc1;
    logic          r_lastr1;

    logic               r_v2;
    logic signed [31:0] r_win [5][5];
    logic [CW-1:0]      r_col2;
    logic [RW-1:0]      r_row2;
    logic               r_lastc2;
    logic               r_lastr2;

    logic [4:0]    vrow;
    logic [4:0]    vcol;
    logic [3:0]    cen;
    logic [3:0]    hit;
    t_event        ev;

    assign lastc = (WW'(r_col) == i_w - WW'(1));
    assign lastr = (HW'(r_row) == i_h - HW'(1));

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_acc) begin
            if (lastc) begin
                r_col <= '0;
                r_row <= lastr ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // four line buffers, one per row slot; read old column, write new pixel
    for (genvar l = 0; l < 4; l++) begin : g_line
        logic [31:0] mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (i_acc) begin
                rd[l] <= mem[r_col];
                if (r_row[1:0] == 2'(l)) mem[r_col] <= i_pixel_value;
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_acc;
            r_v2 <= r_v1;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_pix1   <= i_pixel_value;
            r_col1   <= r_col;
            r_row1   <= r_row;
            r_lastc1 <= lastc;
            r_lastr1 <= lastr;
        end
    end

    // shift the window and load the new column
    always_ff @(posedge i_clk) begin
        if (i_en && r_v1) begin
            for (int j = 0; j < 5; j++) begin
                for (int k = 0; k < 4; k++) begin
                    r_win[j][k] <= r_win[j][k+1];
                end
            end
            for (int j = 0; j < 4; j++) begin
                r_win[j][4] <= rd[2'(r_row1[1:0] + 2'(j))];
            end
            r_win[4][4] <= r_pix1;
            r_col2      <= r_col1;
            r_row2      <= r_row1;
            r_lastc2    <= r_lastc1;
            r_lastr2    <= r_lastr1;
        end
    end

    // candidate centres and in-image masks
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            vrow[j] = (int'(r_row2) + j >= 4);
            vcol[j] = (int'(r_col2) + j >= 4);
        end
        cen[0] = (r_row2 >= RW'(3)) && (r_col2 >= CW'(3));
        cen[1] = (r_row2 >= RW'(3)) && r_lastc2;
        cen[2] = r_lastr2 && (r_col2 >= CW'(3));
        cen[3] = r_lastr2 && r_lastc2;
    end

    // compare each centre with its in-image neighbors
    always_comb begin
        int jc;
        int kc;
        logic ok;
        for (int ci = 0; ci < 4; ci++) begin
            jc = 2 + (ci >> 1);
            kc = 2 + (ci & 1);
            ok = cen[ci] && (r_win[jc][kc] >= $signed(i_thr));
            for (int j = 0; j < 5; j++) begin
                for (int k = 0; k < 5; k++) begin
                    if ((j - jc <= 2) && (jc - j <= 2) && (k - kc <= 2) && (kc - k <= 2)
                        && !(j == jc && k == kc) && vrow[j] && vcol[k]
                        && (r_win[j][k] > r_win[jc][kc])) begin
                        ok = 1'b0;
                    end
                end
            end
            hit[ci]    = ok;
            ev.val[ci] = r_win[jc][kc];
        end
        ev.hit = hit;
        ev.xa  = 11'(r_col2 - CW'(2));
        ev.xb  = 11'(r_col2 - CW'(1));
        ev.ya  = 11'(r_row2 - RW'(2));
        ev.yb  = 11'(r_row2 - RW'(1));
        ev.fin = r_lastc2 && r_lastr2;
    end

    assign o_event = ev;
    assign o_push  = i_en && r_v2 && ((hit != '0) || ev.fin);

endmodule

[rtl/core/lmf_back.sv]
module lmf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_restart,
    input  logic            i_nempty,
    input  lmf_pkg::t_event i_event,
    output logic            o_qpop,
    output logic            empty,
    input  logic            pop,
    output logic            o_result_kind,
    output logic [10:0]     o_spot_x,
    output logic [10:0]     o_spot_y,
    output logic [31:0]     o_spot_intensity,
    output logic [22:0]     o_spot_total,
    output logic            o_last_of_run
);
    import lmf_pkg::*;

    logic        r_busy;
    t_event      r_cur;
    logic [3:0]  r_rem;
    logic [22:0] r_cnt;

    logic        r_ov;
    logic        r_kind;
    logic [10:0] r_x;
    logic [10:0] r_y;
    logic [31:0] r_val;
    logic [22:0] r_total;
    logic        r_last;

    t_event      src;
    logic [3:0]  rem;
    logic [3:0]  sel;
    logic [1:0]  idx;
    logic [3:0]  n_rem;
    logic        done;
    logic        take;

    // pick the working word, lowest remaining spot first
    always_comb begin
        src  = r_busy ? r_cur : i_event;
        rem  = r_busy ? r_rem : i_event.hit;
        take = (!r_ov || pop) && (r_busy || i_nempty);
        if (rem[0]) begin
            idx = 2'd0;
        end else if (rem[1]) begin
            idx = 2'd1;
        end else if (rem[2]) begin
            idx = 2'd2;
        end else begin
            idx = 2'd3;
        end
        sel    = (rem != '0) ? (4'b0001 << idx) : 4'b0000;
        n_rem  = rem & ~sel;
        done   = (rem == '0) || ((n_rem == '0) && !src.fin);
        o_qpop = take && !r_busy;
    end

    // hold the partly expanded word and the frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= !done;
                r_ov   <= 1'b1;
                if (rem != '0) begin
                    if (r_cnt != TOTAL_MAX) r_cnt <= r_cnt + 23'd1;
                end else begin
                    r_cnt <= '0;
                end
            end else if (pop) begin
                r_ov <= 1'b0;
            end
            if (i_restart) r_cnt <= '0;
        end
    end

    // load the output word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur  <= src;
            r_rem  <= n_rem;
            r_last <= done;
            if (rem != '0) begin
                r_kind  <= KIND_SPOT;
                r_x     <= idx[0] ? src.xb : src.xa;
                r_y     <= idx[1] ? src.yb : src.ya;
                r_val   <= src.val[idx];
                r_total <= '0;
            end else begin
                r_kind  <= KIND_SUMMARY;
                r_x     <= '0;
                r_y     <= '0;
                r_val   <= '0;
                r_total <= r_cnt;
            end
        end
    end

    assign empty            = !r_ov;
    assign o_result_kind    = r_kind;
    assign o_spot_x         = r_x;
    assign o_spot_y         = r_y;
    assign o_spot_intensity = r_val;
    assign o_spot_total     = r_total;
    assign o_last_of_run    = r_last;

endmodule

[rtl/core/thresholded_5x5_local_max_finder.sv]
// channel  | handshake      | payload
// ---------+----------------+-----------------------------------------------
// pixel in | push / full    | i_pixel_value
// result   | pop / empty    | o_result_kind, o_spot_x, o_spot_y,
//          |                | o_spot_intensity, o_spot_total, o_last_of_run
// config   | i_cfg_we       | i_cfg_index, i_cfg_data
//
// One pixel per cycle while full is low: line buffer read, window shift, then
// the 5x5 compare, the queue and the output register. A pixel gives up to five
// results (four spots and the frame summary), at one per cycle while pop is held.
// full rises when the four-word queue between compare and output fills.
// Reset is synchronous; line buffers and window are not cleared.
module thresholded_5x5_local_max_finder #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_pixel_value,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [10:0] o_spot_x,
    output logic [10:0] o_spot_y,
    output logic [31:0] o_spot_intensity,
    output logic [22:0] o_spot_total,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import lmf_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);

    logic [31:0]   r_thr;
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [13:0]   cv;
    logic          restart;
    logic          q_full;
    logic          en;
    logic          acc;
    logic          f_push;
    t_event        f_event;
    logic          q_nempty;
    logic          q_pop;
    t_event        q_event;

    assign cv      = {2'b00, i_cfg_data[11:0]};
    assign restart = i_cfg_we && ((i_cfg_index == CFG_WIDTH) || (i_cfg_index == CFG_HEIGHT));
    assign en      = !q_full;
    assign full    = q_full;
    assign acc     = push && en;

    // configuration registers, sizes saturated on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_w   <= WW'(RESET_WIDTH);
            r_h   <= HW'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr <= i_cfg_data;
                CFG_WIDTH: begin
                    if (cv < 14'd3) r_w <= WW'(3);
                    else if (cv > 14'(MAX_WIDTH)) r_w <= WW'(MAX_WIDTH);
                    else r_w <= WW'(cv);
                end
                CFG_HEIGHT: begin
                    if (cv < 14'd3) r_h <= HW'(3);
                    else if (cv > 14'(MAX_HEIGHT)) r_h <= HW'(MAX_HEIGHT);
                    else r_h <= HW'(cv);
                end
                default: ;
            endcase
        end
    end

    lmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_acc         (acc),
        .i_pixel_value (i_pixel_value),
        .i_thr         (r_thr),
        .i_w           (r_w),
        .i_h           (r_h),
        .i_restart     (restart),
        .o_push        (f_push),
        .o_event       (f_event)
    );

    lmf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_event  (f_event),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_nempty (q_nempty),
        .o_event  (q_event)
    );

    lmf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_restart        (restart),
        .i_nempty         (q_nempty),
        .i_event          (q_event),
        .o_qpop           (q_pop),
        .empty            (empty),
        .pop              (pop),
        .o_result_kind    (o_result_kind),
        .o_spot_x         (o_spot_x),
        .o_spot_y         (o_spot_y),
        .o_spot_intensity (o_spot_intensity),
        .o_spot_total     (o_spot_total),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

[dv/thresholded_5x5_local_max_finder_test.sv]
module thresholded_5x5_local_max_finder_test;
    import lmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // index past the register list, must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAXW = 2048;
    localparam int MAXH = 2048;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_op;

    typedef struct {
        t_row_op     op;
        logic [1:0]  idx;
        logic [31:0] data;
        int          total;   // typed summary total on this pixel, -1 if none
    } t_stim_row;

    typedef struct packed {
        logic        kind;
        logic [10:0] x;
        logic [10:0] y;
        logic [31:0] val;
        logic [22:0] total;
        logic        last;
    } t_spot_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_pixel_value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_result_kind;
    logic [10:0] o_spot_x;
    logic [10:0] o_spot_y;
    logic [31:0] o_spot_intensity;
    logic [22:0] o_spot_total;
    logic        o_last_of_run;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    thresholded_5x5_local_max_finder dut (.*);

    always #1 i_clk = ~i_clk;

    // frame model
    logic [31:0] line_mem [4][MAXW];
    logic [31:0] win [5][5];
    int          col_cnt, row_cnt, frame_spots;
    logic [31:0] thr_reg;
    logic [11:0] width_reg, height_reg;
    int          last_total;

    t_spot_word  spot_q [$];
    t_stim_row   dir_rows [$];
    int          errors = 0;
    int          n_items = 0, n_spots = 0, n_frames = 0;
    int          send_idle = 0, recv_stall = 0;

    function automatic int clamp_dim(logic [11:0] v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // centre coordinates decided at position p of a line of n
    function automatic int decided_at(int p, int n, output int l [2]);
        int m = 0;
        if (p == n - 1) begin
            if (n - 3 >= 1) begin
                l[m] = n - 3;
                m++;
            end
            l[m] = n - 2;
            m++;
        end else if (p >= 3) begin
            l[m] = p - 2;
            m++;
        end
        return m;
    endfunction

    function automatic bit window_peak(int cx, int cy, int c, int r, int w, int h);
        int j0 = cy - r + 4;
        int k0 = cx - c + 4;
        int nx, ny, j, k;
        logic signed [31:0] centre;
        if (j0 < 0 || j0 > 4 || k0 < 0 || k0 > 4) return 0;
        centre = win[j0][k0];
        if (centre < $signed(thr_reg)) return 0;
        for (int dy = -2; dy <= 2; dy++) begin
            for (int dx = -2; dx <= 2; dx++) begin
                nx = cx + dx;
                ny = cy + dy;
                j = j0 + dy;
                k = k0 + dx;
                if (dx == 0 && dy == 0) continue;
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                if (j < 0 || j > 4 || k < 0 || k > 4) continue;
                if ($signed(win[j][k]) > centre) return 0;
            end
        end
        return 1;
    endfunction

    // advance the frame model by one pixel and queue the words it causes
    function automatic void predict_spots(logic [31:0] pix);
        int w = clamp_dim(width_reg, MAXW);
        int h = clamp_dim(height_reg, MAXH);
        int c = col_cnt, r = row_cnt;
        int xs [2], ys [2];
        int nxc, nyc;
        t_spot_word step_q [$];
        t_spot_word sw;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        for (int j = 0; j < 5; j++)
            for (int k = 0; k < 4; k++)
                win[j][k] = win[j][k + 1];
        for (int j = 0; j < 4; j++)
            win[j][4] = line_mem[(r + j) & 3][c];
        win[4][4] = pix;
        line_mem[r & 3][c] = pix;
        nyc = decided_at(r, h, ys);
        nxc = decided_at(c, w, xs);
        for (int a = 0; a < nyc; a++) begin
            for (int b = 0; b < nxc; b++) begin
                if (window_peak(xs[b], ys[a], c, r, w, h)) begin
                    sw = '0;
                    sw.kind = KIND_SPOT;
                    sw.x = 11'(xs[b]);
                    sw.y = 11'(ys[a]);
                    sw.val = win[ys[a] - r + 4][xs[b] - c + 4];
                    step_q.push_back(sw);
                    if (frame_spots < int'(TOTAL_MAX)) frame_spots++;
                end
            end
        end
        if (c == w - 1 && r == h - 1) begin
            sw = '0;
            sw.kind = KIND_SUMMARY;
            sw.total = 23'(frame_spots);
            last_total = frame_spots;
            step_q.push_back(sw);
            col_cnt = 0;
            row_cnt = 0;
            frame_spots = 0;
        end else if (c == w - 1) begin
            col_cnt = 0;
            row_cnt = r + 1;
        end else begin
            col_cnt = c + 1;
            row_cnt = r;
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) spot_q.push_back(step_q[i]);
    endfunction

    // hold until every expected word is out, then let the pipe settle
    task automatic drain_spots();
        while (spot_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain_spots();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD: thr_reg = data;
            CFG_WIDTH, CFG_HEIGHT: begin
                if (idx == CFG_WIDTH) width_reg = data[11:0];
                else height_reg = data[11:0];
                col_cnt = 0;
                row_cnt = 0;
                frame_spots = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_pixel(logic [31:0] v);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel_value <= v;
        do @(posedge i_clk); while (full);
        predict_spots(v);
        n_items++;
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(7);
            2: return 32'($urandom_range(7)) - 32'd4;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // take result words and check them against the oldest expectation
    always @(posedge i_clk) begin
        t_spot_word got, want;
        if (i_rst_n && pop && !empty) begin
            got = '{o_result_kind, o_spot_x, o_spot_y, o_spot_intensity,
                    o_spot_total, o_last_of_run};
            if (spot_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %p", got);
            end else begin
                want = spot_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
                if (want.kind == KIND_SUMMARY) n_frames++;
                else n_spots++;
            end
        end
        pop <= ($urandom_range(99) >= recv_stall);
    end

    task automatic add_row(t_row_op op, logic [1:0] idx, logic [31:0] data, int total);
        t_stim_row sr;
        sr = '{op, idx, data, total};
        dir_rows.push_back(sr);
    endtask

    task automatic run_phase(logic [31:0] thr, logic [11:0] w, logic [11:0] h,
                             int idle_pct, int stall_pct, int count);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        send_idle = idle_pct;
        recv_stall = stall_pct;
        for (int i = 0; i < count; i++) send_pixel(rand_pixel());
        push <= 1'b0;
    endtask

    initial begin
        thr_reg = 0;
        width_reg = 12'(RESET_WIDTH);
        height_reg = 12'(RESET_HEIGHT);
        col_cnt = 0;
        row_cnt = 0;
        frame_spots = 0;
        last_total = -1;
        foreach (line_mem[i, j]) line_mem[i][j] = '0;
        foreach (win[i, j]) win[i][j] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lone peak, all-equal frame at the minimum, peak at the maximum
        add_row(ROW_CFG, CFG_WIDTH, 32'd3, -1);
        add_row(ROW_CFG, CFG_HEIGHT, 32'd3, -1);
        for (int i = 0; i < 9; i++) add_row(ROW_PIX, 2'd0, (i == 4) ? 32'd5 : 32'd0,
                                            (i == 8) ? 1 : -1);
        add_row(ROW_CFG, CFG_THRESHOLD, 32'h8000_0000, -1);
        for (int i = 0; i < 9; i++) add_row(ROW_PIX, 2'd0, 32'h8000_0000,
                                            (i == 8) ? 1 : -1);
        add_row(ROW_CFG, CFG_THRESHOLD, 32'h7FFF_FFFF, -1);
        add_row(ROW_CFG, CFG_UNUSED, 32'hFFFF_FFFF, -1);
        add_row(ROW_CFG, CFG_WIDTH, 32'd0, -1);
        for (int i = 0; i < 9; i++) add_row(ROW_PIX, 2'd0,
                                            (i == 4) ? 32'h7FFF_FFFF : 32'h8000_0000,
                                            (i == 8) ? 1 : -1);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                push <= 1'b0;
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_pixel(dir_rows[i].data);
                if (dir_rows[i].total >= 0 && last_total != dir_rows[i].total) begin
                    errors++;
                    $display("directed frame total: expected %0d, model %0d",
                             dir_rows[i].total, last_total);
                end
            end
        end
        push <= 1'b0;

        // random phases; each one ends mid-frame, so the next size write restarts it
        run_phase(32'd0, 12'd5, 12'd4, 0, 0, 48);
        run_phase($urandom(), 12'd7, 12'd6, 82, 0, 46);
        run_phase(32'd1, 12'd3, 12'd3, 0, 82, 46);
        run_phase(32'hFFFF_FFFE, 12'd9, 12'd5, 26, 26, 47);
        run_phase(32'h8000_0000, 12'd1, 12'd2, 26, 26, 30);
        run_phase($urandom(), 12'hFFF, 12'd3, 0, 0, 15);
        run_phase(32'd3, 12'd3, 12'hFFF, 0, 26, 15);
        run_phase($urandom(), 12'd4, 12'd8, 82, 82, 40);

        drain_spots();
        $display("%0d pixels over several frame sizes, thresholds and idle mixes", n_items);
        $display("%0d spot words and %0d frame summaries checked", n_spots, n_frames);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hard stop on a hang
    initial begin
        #2_000_000;
        $display("timeout with %0d words outstanding", spot_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/lmf_pkg.sv
rtl/core/lmf_queue.sv
rtl/core/lmf_front.sv
rtl/core/lmf_back.sv
rtl/core/thresholded_5x5_local_max_finder.sv
dv/thresholded_5x5_local_max_finder_test.sv
